// ===== rtl/core/tce_pkg.sv =====
// ---------------------------------------------------------------------------
// tce_pkg
// Shared widths, register indexes, result kinds and edge arithmetic for the
// threshold crossing edge unit.
// ---------------------------------------------------------------------------
package tce_pkg;

  localparam int PixelW     = 8;
  localparam int ThrW       = 8;
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 13;
  localparam int CfgDataW   = 13;
  localparam int CfgIdxW    = 2;
  localparam int OutRowW    = 13;
  localparam int OutColW    = 11;

  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 4096;

  localparam logic [ThrW-1:0]       ThrReset    = '0;
  localparam logic [WidthRegW-1:0]  WidthReset  = 11'd1024;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd1024;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWidth     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeight    = 2'd2;

  // result kinds, in emission order
  typedef logic [1:0] res_kind_t;
  localparam res_kind_t ResUpLeft = 2'd0;  // diagonal 2x2 result, always present
  localparam res_kind_t ResUp     = 2'd1;  // last column, line above
  localparam res_kind_t ResLeft   = 2'd2;  // last line, pixel to the left
  localparam res_kind_t ResCorner = 2'd3;  // last pixel of frame, strength 0

  typedef logic [PixelW-1:0] pixel_t;

  function automatic pixel_t edge_from(pixel_t centre, pixel_t nb, logic [ThrW-1:0] thr);
    pixel_t res;
    res = '0;
    if (centre <= thr) begin
      if (nb > thr) res = nb - centre;
    end else begin
      if (nb <= thr) res = centre - nb;
    end
    return res;
  endfunction

  function automatic pixel_t edge_two(pixel_t centre, pixel_t right, pixel_t below,
                                      logic [ThrW-1:0] thr);
    pixel_t nb;
    if (centre <= thr) nb = (below > right) ? below : right;
    else               nb = (below < right) ? below : right;
    return edge_from(centre, nb, thr);
  endfunction

endpackage

// ===== rtl/core/threshold_crossing_edge_unit.sv =====
// ---------------------------------------------------------------------------
// threshold_crossing_edge_unit
// Streaming 2x2 threshold crossing edge detector with one line store.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------
//  pixel    | in        | in_valid_i / in_stall_o  | pixel_i
//  result   | out       | out_valid_o / out_stall_i| strength_o, out_row_o,
//           |           |                        | out_col_o, last_of_item_o
//  config   | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
//  One pixel request per cycle while each pixel yields at most one result and
//  the output does not stall. A pixel in the last column or last line holds
//  the input while it hands its results (two, four for the last pixel of the
//  frame) to the single output register, which takes one result per cycle unless stalled.
//  Reset clears counters, neighbor registers and valid flags; the line store
//  needs no clearing pass. Output stall backs up into in_stall_o through the
//  result sequencer in the same cycle.
//
module threshold_crossing_edge_unit
  import tce_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  // pixel requests
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PixelW-1:0]     pixel_i,
  // result requests
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PixelW-1:0]     strength_o,
  output logic [OutRowW-1:0]    out_row_o,
  output logic [OutColW-1:0]    out_col_o,
  output logic                  last_of_item_o
);

  localparam int ColCntW = $clog2(MAX_WIDTH + 1);
  localparam int RowCntW = $clog2(MAX_HEIGHT + 1);
  localparam int AddrW   = $clog2(MAX_WIDTH);
  localparam int WCmpW   = (ColCntW > WidthRegW) ? ColCntW : WidthRegW;
  localparam int HCmpW   = (RowCntW > HeightRegW) ? RowCntW : HeightRegW;

  // ---------------- configuration registers ----------------
  logic [ThrW-1:0]       thr_q;
  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThrReset;
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegThreshold: thr_q    <= cfg_data_i[ThrW-1:0];
        RegWidth:     width_q  <= cfg_data_i[WidthRegW-1:0];
        RegHeight:    height_q <= cfg_data_i[HeightRegW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // geometry in use, saturated to 2..MAX
  logic [WCmpW-1:0]   width_x;
  logic [HCmpW-1:0]   height_x;
  logic [ColCntW-1:0] w_lim;
  logic [RowCntW-1:0] h_lim;

  always_comb begin
    width_x  = WCmpW'(width_q);
    height_x = HCmpW'(height_q);
    if (width_x < WCmpW'(2))              w_lim = ColCntW'(2);
    else if (width_x > WCmpW'(MAX_WIDTH)) w_lim = ColCntW'(MAX_WIDTH);
    else                                  w_lim = ColCntW'(width_x);
    if (height_x < HCmpW'(2))               h_lim = RowCntW'(2);
    else if (height_x > HCmpW'(MAX_HEIGHT)) h_lim = RowCntW'(MAX_HEIGHT);
    else                                    h_lim = RowCntW'(height_x);
  end

  // ---------------- accept stage: raster counters and line store ----------------
  logic               in_acc;
  logic [ColCntW-1:0] col_q, col_d;
  logic [RowCntW-1:0] row_q, row_d;
  logic               at_last_col, at_last_row;
  logic [AddrW-1:0]   mem_addr;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign at_last_col = (col_q >= w_lim);
  assign at_last_row = (row_q >= h_lim);
  assign mem_addr    = AddrW'(col_q - ColCntW'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (at_last_col) begin
        col_d = ColCntW'(1);
        row_d = at_last_row ? RowCntW'(1) : RowCntW'(row_q + RowCntW'(1));
      end else begin
        col_d = ColCntW'(col_q + ColCntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= ColCntW'(1);
      row_q <= RowCntW'(1);
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line store: read and write of the same column in one cycle. The read
  // returns the old entry (pixel of the line above) while the new pixel
  // replaces it, so no forwarding path is needed. Consecutive pixels never
  // share a column since a line is at least two pixels.
  logic [PixelW-1:0] line_mem [MAX_WIDTH];
  logic [PixelW-1:0] above_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_q            <= line_mem[mem_addr];
      line_mem[mem_addr] <= pixel_i;
    end
  end

  // ---------------- result stage ----------------
  logic               s1_valid_q;
  logic [PixelW-1:0]  s1_px_q;
  logic [ColCntW-1:0] s1_col_q;
  logic [RowCntW-1:0] s1_row_q;
  logic               s1_lc_q, s1_lr_q, s1_emit_q;
  res_kind_t          kind_q, kind_d, kind_nxt;
  logic [PixelW-1:0]  left_q, ul_q;

  logic out_free, hand, retire, is_last;

  // after the current kind: is another result due, and which one
  always_comb begin
    is_last  = 1'b1;
    kind_nxt = ResUpLeft;
    unique case (kind_q)
      ResUpLeft: begin
        is_last  = !(s1_lc_q || s1_lr_q);
        kind_nxt = s1_lc_q ? ResUp : ResLeft;
      end
      ResUp: begin
        is_last  = !s1_lr_q;
        kind_nxt = ResLeft;
      end
      ResLeft: begin
        is_last  = !s1_lc_q;
        kind_nxt = ResCorner;
      end
      ResCorner: begin
        is_last  = 1'b1;
        kind_nxt = ResUpLeft;
      end
    endcase
  end

  assign out_free   = !out_valid_o || !out_stall_i;
  assign hand       = s1_valid_q && s1_emit_q && out_free;
  assign retire     = s1_valid_q && (!s1_emit_q || (out_free && is_last));
  assign in_stall_o = s1_valid_q && !retire;

  always_comb begin
    kind_d = kind_q;
    if (retire)    kind_d = ResUpLeft;
    else if (hand) kind_d = kind_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      kind_q     <= ResUpLeft;
      left_q     <= '0;
      ul_q       <= '0;
    end else begin
      kind_q <= kind_d;
      if (in_acc)      s1_valid_q <= 1'b1;
      else if (retire) s1_valid_q <= 1'b0;
      // neighbors move on when the pixel leaves the result stage
      if (retire) begin
        left_q <= s1_px_q;
        ul_q   <= above_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q   <= pixel_i;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_lc_q   <= at_last_col;
      s1_lr_q   <= at_last_row;
      s1_emit_q <= (row_q >= RowCntW'(2)) && (col_q >= ColCntW'(2));
    end
  end

  // current result
  logic [PixelW-1:0]  res_str;
  logic [RowCntW-1:0] res_row;
  logic [ColCntW-1:0] res_col;

  always_comb begin
    unique case (kind_q)
      ResUpLeft: begin
        res_str = edge_two(ul_q, above_q, left_q, thr_q);
        res_row = RowCntW'(s1_row_q - RowCntW'(1));
        res_col = ColCntW'(s1_col_q - ColCntW'(1));
      end
      ResUp: begin
        res_str = edge_from(above_q, s1_px_q, thr_q);
        res_row = RowCntW'(s1_row_q - RowCntW'(1));
        res_col = s1_col_q;
      end
      ResLeft: begin
        res_str = edge_from(left_q, s1_px_q, thr_q);
        res_row = s1_row_q;
        res_col = ColCntW'(s1_col_q - ColCntW'(1));
      end
      ResCorner: begin
        res_str = '0;
        res_row = s1_row_q;
        res_col = s1_col_q;
      end
    endcase
  end

  // ---------------- output register ----------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= hand;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hand) begin
      strength_o     <= res_str;
      out_row_o      <= OutRowW'(res_row);
      out_col_o      <= OutColW'(res_col);
      last_of_item_o <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/tce_checker.sv =====
// ---------------------------------------------------------------------------
// tce_checker
// Port-level assertions for the threshold crossing edge unit, bound in below.
// ---------------------------------------------------------------------------
module tce_checker
  import tce_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [PixelW-1:0]   strength_o,
  input logic [OutRowW-1:0]  out_row_o,
  input logic [OutColW-1:0]  out_col_o,
  input logic                last_of_item_o
);

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;

  // stalled result request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(strength_o) && $stable(out_row_o) && $stable(out_col_o) &&
      $stable(last_of_item_o))
    else $error("stalled result changed");

  // a pixel held back always means a result shows next cycle
  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o)
    else $error("input stalled with no result pending");

  // results of one pixel come without gaps
  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_of_item_o |=> out_valid_o)
    else $error("gap inside a pixel's results");

  // next result of the same pixel is on the same line or one below
  a_burst_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_of_item_o |=>
      (out_row_o == $past(out_row_o)) ||
      (out_row_o == OutRowW'($past(out_row_o) + OutRowW'(1))))
    else $error("result line jumped inside a pixel's results");

  // a left-neighbor result that follows an upper one is only seen on the
  // last pixel of the frame; the corner result after it has no strength
  // and closes its pixel
  a_corner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_of_item_o ##1
      out_acc && !last_of_item_o &&
      out_row_o == OutRowW'($past(out_row_o) + OutRowW'(1))
    |=> out_valid_o && strength_o == '0 && last_of_item_o)
    else $error("corner result with strength or not closing its pixel");

endmodule

bind threshold_crossing_edge_unit tce_checker u_tce_checker (.*);
